// ===== rtl/core/smsu_pkg.sv =====
`default_nettype none
package smsu_pkg;

	localparam int COORD_W = 32;
	localparam int LINE_W  = 8;
	localparam int SEG_W   = 12;
	localparam int SCORE_W = 17;
	localparam int TOL_W   = 31;
	localparam int DMAX_W  = 32;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 2;
	localparam int MAG_W   = 36;
	localparam int ANG_W   = 31;

	localparam logic [CIDX_W-1:0] CFG_TOL  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_MTOL = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_DMAX = 2'd2;

	localparam logic [ANG_W-1:0]   PIH_Q30      = 31'd1686629713;
	localparam logic [31:0]        INVK_Q30     = 32'd652032874;
	localparam logic [19:0]        RECIP3       = 20'd699051;
	localparam int                 RECIP3_SHIFT = 21;
	localparam logic [SCORE_W-1:0] MTOL_RESET   = 17'd45875;

	typedef enum logic [2:0] {
		JOB_MID,
		JOB_ANG,
		JOB_L1,
		JOB_L2,
		JOB_D1,
		JOB_D2
	} cjob_t;

	typedef enum logic [1:0] {
		DJOB_LEN,
		DJOB_ANG,
		DJOB_DST
	} djob_t;

	typedef enum logic [1:0] {
		MUL_PX_QX,
		MUL_PY_QY,
		MUL_PX_QY,
		MUL_PY_QX
	} msel_t;

	typedef struct packed {
		logic  load;
		logic  norm_step;
		logic  mul_en;
		msel_t mul_sel;
		logic  acc_load;
		logic  dot_load;
		logic  crs_load;
		logic  cordic_start;
		cjob_t cjob;
		logic  div_start;
		djob_t djob;
		logic  score_mul;
		logic  score_load;
		logic  score_clear;
		logic  update;
		logic  emit;
	} smsu_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic cordic_done;
		logic div_done;
		logic mid_ok;
		logic terms_ok;
		logic last;
		logic out_busy;
	} smsu_status_t;

	function automatic logic [ANG_W-1:0] atan_q30(input logic [4:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			5'd0:    a = 31'd843314857;
			5'd1:    a = 31'd497837829;
			5'd2:    a = 31'd263043837;
			5'd3:    a = 31'd133525159;
			5'd4:    a = 31'd67021687;
			5'd5:    a = 31'd33543516;
			5'd6:    a = 31'd16775851;
			5'd7:    a = 31'd8388437;
			5'd8:    a = 31'd4194283;
			5'd9:    a = 31'd2097149;
			5'd10:   a = 31'd1048576;
			default: a = 31'd1 << (5'd30 - i);
		endcase
		return a;
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/smsu_cordic.sv =====
`default_nettype none
module smsu_cordic (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] ax,
	input  wire logic [63:0] ay,
	output logic             done,
	output logic [63:0]      mag,
	output logic [smsu_pkg::ANG_W-1:0] ang
);

	typedef enum logic [5:0] {
		C_IDLE = 6'b000001,
		C_NORM = 6'b000010,
		C_ITER = 6'b000100,
		C_MAG1 = 6'b001000,
		C_MAG2 = 6'b010000,
		C_FIN  = 6'b100000
	} cstate_t;

	cstate_t            state_q;
	logic signed [63:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic signed [6:0]  sh_q;
	logic [4:0]         i_q;
	logic [63:0]        mp_q, acc_q;
	logic               done_q;
	logic [63:0]        mag_q;
	logic [smsu_pkg::ANG_W-1:0] ang_q;

	logic [63:0]        ux, uy, mx, xm, mprod, msum, mshift;
	logic [31:0]        mop;
	logic signed [63:0] xs, ys;
	logic signed [33:0] za;
	logic [5:0]         rsh;

	assign ux = $unsigned(x_q);
	assign uy = $unsigned(y_q);
	assign mx = (ux > uy) ? ux : uy;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign za = $signed({3'b000, smsu_pkg::atan_q30(i_q)});
	assign xm = x_q[63] ? 64'd0 : ux;
	assign mop = (state_q == C_MAG1) ? xm[61:30] : {2'b00, xm[29:0]};
	assign mprod = {32'd0, mop} * {32'd0, smsu_pkg::INVK_Q30};
	assign msum = acc_q + (mp_q >> 30);
	assign rsh = 6'(-sh_q);
	assign mshift = (sh_q > 7'sd0) ? (msum << sh_q[5:0]) : (msum >> rsh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						if (ax == 64'd0 && ay == 64'd0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= C_NORM;
						end
					end
				end
				C_NORM: begin
					if (mx[63:53] == 11'd0 && mx[52]) begin
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (i_q == 5'd30) begin
						state_q <= C_MAG1;
					end
				end
				C_MAG1: state_q <= C_MAG2;
				C_MAG2: state_q <= C_FIN;
				C_FIN: begin
					state_q <= C_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					x_q   <= $signed(ax);
					y_q   <= $signed(ay);
					sh_q  <= 7'sd0;
					mag_q <= 64'd0;
					ang_q <= '0;
				end
			end
			C_NORM: begin
				i_q <= 5'd0;
				z_q <= 34'sd0;
				if (mx[63:53] != 11'd0) begin
					x_q  <= $signed(ux >> 1);
					y_q  <= $signed(uy >> 1);
					sh_q <= sh_q + 7'sd1;
				end else if (mx[52:37] == 16'd0) begin
					x_q  <= $signed(ux << 16);
					y_q  <= $signed(uy << 16);
					sh_q <= sh_q - 7'sd16;
				end else if (mx[52:45] == 8'd0) begin
					x_q  <= $signed(ux << 8);
					y_q  <= $signed(uy << 8);
					sh_q <= sh_q - 7'sd8;
				end else if (mx[52:49] == 4'd0) begin
					x_q  <= $signed(ux << 4);
					y_q  <= $signed(uy << 4);
					sh_q <= sh_q - 7'sd4;
				end else if (mx[52:51] == 2'd0) begin
					x_q  <= $signed(ux << 2);
					y_q  <= $signed(uy << 2);
					sh_q <= sh_q - 7'sd2;
				end else if (!mx[52]) begin
					x_q  <= $signed(ux << 1);
					y_q  <= $signed(uy << 1);
					sh_q <= sh_q - 7'sd1;
				end
			end
			C_ITER: begin
				if (!y_q[63]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + za;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - za;
				end
				i_q <= i_q + 5'd1;
			end
			C_MAG1: mp_q <= mprod;
			C_MAG2: begin
				acc_q <= mp_q;
				mp_q  <= mprod;
			end
			C_FIN: begin
				mag_q <= mshift;
				if (z_q[33]) begin
					ang_q <= '0;
				end else if (z_q > $signed({3'b000, smsu_pkg::PIH_Q30})) begin
					ang_q <= smsu_pkg::PIH_Q30;
				end else begin
					ang_q <= z_q[smsu_pkg::ANG_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign mag  = mag_q;
	assign ang  = ang_q;

endmodule
`default_nettype wire

// ===== rtl/core/smsu_div.sv =====
`default_nettype none
module smsu_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] a,
	input  wire logic [31:0] d,
	output logic             done,
	output logic [smsu_pkg::SCORE_W-1:0] q
);

	// The dividend never exceeds the divisor, so the quotient has one integer
	// bit and sixteen fraction bits.
	logic [32:0] rem_q, trial, rem_d;
	logic [31:0] d_q;
	logic [smsu_pkg::SCORE_W-1:0] q_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q, qbit;

	assign trial = (cnt_q == 5'd0) ? rem_q : {rem_q[31:0], 1'b0};
	assign qbit  = trial >= {1'b0, d_q};
	assign rem_d = qbit ? (trial - {1'b0, d_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, a};
			d_q   <= d;
		end else if (busy_q) begin
			rem_q <= rem_d;
			q_q   <= {q_q[smsu_pkg::SCORE_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule
`default_nettype wire

// ===== rtl/core/smsu_ctrl.sv =====
`default_nettype none
module smsu_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire smsu_pkg::smsu_status_t st,
	output smsu_pkg::smsu_cmd_t         cmd
);

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_NORM   = 16'h0002,
		S_MUL0   = 16'h0004,
		S_MUL1   = 16'h0008,
		S_MUL2   = 16'h0010,
		S_MUL3   = 16'h0020,
		S_MUL4   = 16'h0040,
		S_CSTART = 16'h0080,
		S_CWAIT  = 16'h0100,
		S_CHECK  = 16'h0200,
		S_DSTART = 16'h0400,
		S_DWAIT  = 16'h0800,
		S_SUM    = 16'h1000,
		S_SCORE  = 16'h2000,
		S_UPDATE = 16'h4000,
		S_EMIT   = 16'h8000
	} state_t;

	state_t          state_q, state_d;
	smsu_pkg::cjob_t cjob_q, cjob_d;
	smsu_pkg::djob_t djob_q, djob_d;

	always_comb begin
		state_d  = state_q;
		cjob_d   = cjob_q;
		djob_d   = djob_q;
		cmd      = '0;
		cmd.cjob = cjob_q;
		cmd.djob = djob_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_NORM;
				end
			end
			S_NORM: begin
				if (st.norm_done) begin
					state_d = S_MUL0;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = smsu_pkg::MUL_PX_QX;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = smsu_pkg::MUL_PY_QY;
				cmd.acc_load = 1'b1;
				state_d      = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = smsu_pkg::MUL_PX_QY;
				cmd.dot_load = 1'b1;
				state_d      = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = smsu_pkg::MUL_PY_QX;
				cmd.acc_load = 1'b1;
				state_d      = S_MUL4;
			end
			S_MUL4: begin
				cmd.crs_load = 1'b1;
				cjob_d       = smsu_pkg::JOB_MID;
				state_d      = S_CSTART;
			end
			S_CSTART: begin
				cmd.cordic_start = 1'b1;
				state_d          = S_CWAIT;
			end
			S_CWAIT: begin
				if (st.cordic_done) begin
					if (cjob_q == smsu_pkg::JOB_MID) begin
						if (st.mid_ok) begin
							cjob_d  = smsu_pkg::JOB_ANG;
							state_d = S_CSTART;
						end else begin
							cmd.score_clear = 1'b1;
							state_d         = S_UPDATE;
						end
					end else if (cjob_q == smsu_pkg::JOB_D2) begin
						state_d = S_CHECK;
					end else begin
						cjob_d  = smsu_pkg::cjob_t'(cjob_q + 3'd1);
						state_d = S_CSTART;
					end
				end
			end
			S_CHECK: begin
				if (st.terms_ok) begin
					djob_d  = smsu_pkg::DJOB_LEN;
					state_d = S_DSTART;
				end else begin
					cmd.score_clear = 1'b1;
					state_d         = S_UPDATE;
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (st.div_done) begin
					if (djob_q == smsu_pkg::DJOB_DST) begin
						state_d = S_SUM;
					end else begin
						djob_d  = smsu_pkg::djob_t'(djob_q + 2'd1);
						state_d = S_DSTART;
					end
				end
			end
			S_SUM: begin
				cmd.score_mul = 1'b1;
				state_d       = S_SCORE;
			end
			S_SCORE: begin
				cmd.score_load = 1'b1;
				state_d        = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = st.last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cjob_q  <= smsu_pkg::JOB_MID;
			djob_q  <= smsu_pkg::DJOB_LEN;
		end else begin
			state_q <= state_d;
			cjob_q  <= cjob_d;
			djob_q  <= djob_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/smsu_datapath.sv =====
`default_nettype none
module smsu_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [smsu_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [smsu_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] subj_x0,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] subj_y0,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] subj_x1,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] subj_y1,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] ref_x0,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] ref_y0,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] ref_x1,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] ref_y1,
	input  wire logic [smsu_pkg::LINE_W-1:0] line_number,
	input  wire logic [smsu_pkg::SEG_W-1:0]  segment_number,
	input  wire logic last_of_query,
	input  wire smsu_pkg::smsu_cmd_t cmd,
	output smsu_pkg::smsu_status_t   st,
	input  wire logic out_ready,
	output logic out_valid,
	output logic match_found,
	output logic [smsu_pkg::SCORE_W-1:0] best_score,
	output logic signed [smsu_pkg::COORD_W-1:0] mean_x0,
	output logic signed [smsu_pkg::COORD_W-1:0] mean_y0,
	output logic signed [smsu_pkg::COORD_W-1:0] mean_x1,
	output logic signed [smsu_pkg::COORD_W-1:0] mean_y1,
	output logic [smsu_pkg::LINE_W-1:0] matched_line,
	output logic [smsu_pkg::SEG_W-1:0]  matched_segment,
	output logic was_reversed
);

	localparam int CW = smsu_pkg::COORD_W;
	localparam int SW = smsu_pkg::SCORE_W;
	localparam int MW = smsu_pkg::MAG_W;

	logic [smsu_pkg::TOL_W-1:0]  tol_q;
	logic [SW-1:0]               mtol_q;
	logic [smsu_pkg::DMAX_W-1:0] dmax_q;

	logic signed [CW-1:0] s_q [4];
	logic signed [CW-1:0] r_q [4];
	logic [smsu_pkg::LINE_W-1:0] line_q;
	logic [smsu_pkg::SEG_W-1:0]  seg_q;
	logic last_q;

	logic signed [32:0] px_q, py_q, qx_q, qy_q;
	logic signed [63:0] prod_q, acc_q, dot_q, crs_q;
	logic [MW-1:0] l1_q, l2_q, d1_q, d2_q;
	logic [smsu_pkg::ANG_W-1:0] z_q;
	logic [SW-1:0] s1_q, s2_q, s3_q, score_q;

	logic [SW-1:0]        best_score_q;
	logic signed [CW-1:0] best_ref_q [4];
	logic [smsu_pkg::LINE_W-1:0] best_line_q;
	logic [smsu_pkg::SEG_W-1:0]  best_seg_q;
	logic best_rev_q;

	logic out_valid_q;

	logic signed [CW-1:0] rr [4];
	logic signed [32:0] ux, uy, vx, vy;
	logic signed [63:0] mdx, mdy, e0x, e0y, e1x, e1y;
	logic rev;
	logic [31:0] two_tol;
	logic [MW-1:0] diff;
	logic [MW:0] dsum;
	logic signed [31:0] ma, mb;
	logic signed [63:0] mul_p;
	logic [63:0] cax, cay, cmag;
	logic [smsu_pkg::ANG_W-1:0] cang;
	logic cdone, ddone;
	logic [31:0] da, dd;
	logic [SW-1:0] dq;
	logic [SW:0] ssum;
	logic pass, found;
	logic signed [63:0] msum [4];

	function automatic logic big30(input logic signed [32:0] v);
		return (v >= 33'sd1073741824) || (v <= -33'sd1073741824);
	endfunction

	assign ux = 33'(s_q[2]) - 33'(s_q[0]);
	assign uy = 33'(s_q[3]) - 33'(s_q[1]);
	assign vx = 33'(r_q[2]) - 33'(r_q[0]);
	assign vy = 33'(r_q[3]) - 33'(r_q[1]);

	assign rev = dot_q[63];
	assign rr[0] = rev ? r_q[2] : r_q[0];
	assign rr[1] = rev ? r_q[3] : r_q[1];
	assign rr[2] = rev ? r_q[0] : r_q[2];
	assign rr[3] = rev ? r_q[1] : r_q[3];

	assign mdx = (64'(s_q[0]) + 64'(s_q[2])) - (64'(r_q[0]) + 64'(r_q[2]));
	assign mdy = (64'(s_q[1]) + 64'(s_q[3])) - (64'(r_q[1]) + 64'(r_q[3]));
	assign e0x = 64'(s_q[0]) - 64'(rr[0]);
	assign e0y = 64'(s_q[1]) - 64'(rr[1]);
	assign e1x = 64'(s_q[2]) - 64'(rr[2]);
	assign e1y = 64'(s_q[3]) - 64'(rr[3]);

	assign two_tol = {tol_q, 1'b0};
	assign diff = (l1_q > l2_q) ? (l1_q - l2_q) : (l2_q - l1_q);
	assign dsum = {1'b0, d1_q} + {1'b0, d2_q};

	always_comb begin
		case (cmd.cjob)
			smsu_pkg::JOB_MID: begin
				cax = smsu_pkg::abs64(mdx);
				cay = smsu_pkg::abs64(mdy);
			end
			smsu_pkg::JOB_ANG: begin
				cax = smsu_pkg::abs64(dot_q);
				cay = smsu_pkg::abs64(crs_q);
			end
			smsu_pkg::JOB_L1: begin
				cax = smsu_pkg::abs64(64'(ux));
				cay = smsu_pkg::abs64(64'(uy));
			end
			smsu_pkg::JOB_L2: begin
				cax = smsu_pkg::abs64(64'(vx));
				cay = smsu_pkg::abs64(64'(vy));
			end
			smsu_pkg::JOB_D1: begin
				cax = smsu_pkg::abs64(e0x);
				cay = smsu_pkg::abs64(e0y);
			end
			smsu_pkg::JOB_D2: begin
				cax = smsu_pkg::abs64(e1x);
				cay = smsu_pkg::abs64(e1y);
			end
			default: begin
				cax = 64'd0;
				cay = 64'd0;
			end
		endcase
	end

	smsu_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cordic_start),
		.ax     (cax),
		.ay     (cay),
		.done   (cdone),
		.mag    (cmag),
		.ang    (cang)
	);

	always_comb begin
		case (cmd.djob)
			smsu_pkg::DJOB_LEN: begin
				da = dmax_q - diff[31:0];
				dd = dmax_q;
			end
			smsu_pkg::DJOB_ANG: begin
				da = {1'b0, smsu_pkg::PIH_Q30 - z_q};
				dd = {1'b0, smsu_pkg::PIH_Q30};
			end
			smsu_pkg::DJOB_DST: begin
				da = two_tol - dsum[31:0];
				dd = two_tol;
			end
			default: begin
				da = 32'd0;
				dd = 32'd1;
			end
		endcase
	end

	smsu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.a      (da),
		.d      (dd),
		.done   (ddone),
		.q      (dq)
	);

	always_comb begin
		if (cmd.score_mul) begin
			ma = $signed({14'd0, ssum});
			mb = $signed({12'd0, smsu_pkg::RECIP3});
		end else begin
			case (cmd.mul_sel)
				smsu_pkg::MUL_PX_QX: begin
					ma = px_q[31:0];
					mb = qx_q[31:0];
				end
				smsu_pkg::MUL_PY_QY: begin
					ma = py_q[31:0];
					mb = qy_q[31:0];
				end
				smsu_pkg::MUL_PX_QY: begin
					ma = px_q[31:0];
					mb = qy_q[31:0];
				end
				default: begin
					ma = py_q[31:0];
					mb = qx_q[31:0];
				end
			endcase
		end
	end

	assign mul_p = ma * mb;
	assign ssum  = {1'b0, s1_q} + {1'b0, s2_q} + {1'b0, s3_q};
	assign pass  = (s1_q > mtol_q) && (s2_q > mtol_q) && (s3_q > mtol_q);
	assign found = best_score_q > mtol_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			msum[k] = 64'(s_q[k]) + 64'(best_ref_q[k]);
		end
	end

	assign st.norm_done   = !big30(px_q) && !big30(py_q) && !big30(qx_q) && !big30(qy_q);
	assign st.cordic_done = cdone;
	assign st.div_done    = ddone;
	assign st.mid_ok      = (cmag < {32'd0, two_tol}) && !(ux == 33'sd0 && uy == 33'sd0)
		&& !(vx == 33'sd0 && vy == 33'sd0);
	assign st.terms_ok    = (dmax_q != 32'd0) && (diff < {4'd0, dmax_q})
		&& (dsum < {5'd0, two_tol});
	assign st.last        = last_q;
	assign st.out_busy    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= '0;
			mtol_q <= smsu_pkg::MTOL_RESET;
			dmax_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				smsu_pkg::CFG_TOL:  tol_q  <= cfg_data[smsu_pkg::TOL_W-1:0];
				smsu_pkg::CFG_MTOL: mtol_q <= cfg_data[SW-1:0];
				smsu_pkg::CFG_DMAX: dmax_q <= cfg_data[smsu_pkg::DMAX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q[0] <= subj_x0;
			s_q[1] <= subj_y0;
			s_q[2] <= subj_x1;
			s_q[3] <= subj_y1;
			r_q[0] <= ref_x0;
			r_q[1] <= ref_y0;
			r_q[2] <= ref_x1;
			r_q[3] <= ref_y1;
			line_q <= line_number;
			seg_q  <= segment_number;
			last_q <= last_of_query;
			px_q   <= 33'(subj_x1) - 33'(subj_x0);
			py_q   <= 33'(subj_y1) - 33'(subj_y0);
			qx_q   <= 33'(ref_x1) - 33'(ref_x0);
			qy_q   <= 33'(ref_y1) - 33'(ref_y0);
		end else if (cmd.norm_step) begin
			if (big30(px_q) || big30(py_q)) begin
				px_q <= px_q >>> 1;
				py_q <= py_q >>> 1;
			end
			if (big30(qx_q) || big30(qy_q)) begin
				qx_q <= qx_q >>> 1;
				qy_q <= qy_q >>> 1;
			end
		end
		if (cmd.mul_en || cmd.score_mul) begin
			prod_q <= mul_p;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end
		if (cmd.dot_load) begin
			dot_q <= acc_q + prod_q;
		end
		if (cmd.crs_load) begin
			crs_q <= acc_q - prod_q;
		end
		if (cdone) begin
			case (cmd.cjob)
				smsu_pkg::JOB_ANG: begin
					if (crs_q == 64'sd0) begin
						z_q <= '0;
					end else if (dot_q == 64'sd0) begin
						z_q <= smsu_pkg::PIH_Q30;
					end else begin
						z_q <= cang;
					end
				end
				smsu_pkg::JOB_L1: l1_q <= cmag[MW-1:0];
				smsu_pkg::JOB_L2: l2_q <= cmag[MW-1:0];
				smsu_pkg::JOB_D1: d1_q <= cmag[MW-1:0];
				smsu_pkg::JOB_D2: d2_q <= cmag[MW-1:0];
				default: ;
			endcase
		end
		if (ddone) begin
			case (cmd.djob)
				smsu_pkg::DJOB_LEN: s1_q <= dq;
				smsu_pkg::DJOB_ANG: s2_q <= dq;
				default:            s3_q <= dq;
			endcase
		end
		if (cmd.score_clear) begin
			score_q <= '0;
		end else if (cmd.score_load) begin
			score_q <= pass ? prod_q[smsu_pkg::RECIP3_SHIFT +: SW] : '0;
		end
		if (cmd.emit) begin
			match_found     <= found;
			best_score      <= best_score_q;
			mean_x0         <= found ? msum[0][CW:1] : '0;
			mean_y0         <= found ? msum[1][CW:1] : '0;
			mean_x1         <= found ? msum[2][CW:1] : '0;
			mean_y1         <= found ? msum[3][CW:1] : '0;
			matched_line    <= found ? best_line_q : '0;
			matched_segment <= found ? best_seg_q : '0;
			was_reversed    <= found && best_rev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_line_q  <= '0;
			best_seg_q   <= '0;
			best_rev_q   <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				best_ref_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				best_score_q <= '0;
				best_line_q  <= '0;
				best_seg_q   <= '0;
				best_rev_q   <= 1'b0;
				for (int k = 0; k < 4; k++) begin
					best_ref_q[k] <= '0;
				end
			end else if (cmd.update && score_q > best_score_q) begin
				best_score_q <= score_q;
				best_line_q  <= line_q;
				best_seg_q   <= seg_q;
				best_rev_q   <= rev;
				for (int k = 0; k < 4; k++) begin
					best_ref_q[k] <= rr[k];
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/segment_match_scorer_unit.sv =====
`default_nettype none
// Scores one candidate reference segment against a subject segment per
// request and keeps the best match of a query; the request flagged as last of
// its query produces one result with the averaged segment. All lengths,
// distances and the angle come from one shared 31-step CORDIC unit, and the
// three score terms from one shared divider. A candidate that passes the
// midpoint test goes through six CORDIC runs, three divisions, the products
// and bookkeeping; a candidate rejected at the midpoint test stops after its
// first CORDIC run. One request is processed at a time; a finished result
// waits in the output register while the next request is taken in.
module segment_match_scorer_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [smsu_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [smsu_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] subj_x0,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] subj_y0,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] subj_x1,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] subj_y1,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] ref_x0,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] ref_y0,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] ref_x1,
	input  wire logic signed [smsu_pkg::COORD_W-1:0] ref_y1,
	input  wire logic [smsu_pkg::LINE_W-1:0] line_number,
	input  wire logic [smsu_pkg::SEG_W-1:0]  segment_number,
	input  wire logic last_of_query,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      match_found,
	output logic [smsu_pkg::SCORE_W-1:0] best_score,
	output logic signed [smsu_pkg::COORD_W-1:0] mean_x0,
	output logic signed [smsu_pkg::COORD_W-1:0] mean_y0,
	output logic signed [smsu_pkg::COORD_W-1:0] mean_x1,
	output logic signed [smsu_pkg::COORD_W-1:0] mean_y1,
	output logic [smsu_pkg::LINE_W-1:0] matched_line,
	output logic [smsu_pkg::SEG_W-1:0]  matched_segment,
	output logic was_reversed
);

	smsu_pkg::smsu_cmd_t    cmd;
	smsu_pkg::smsu_status_t st;

	smsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	smsu_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.subj_x0         (subj_x0),
		.subj_y0         (subj_y0),
		.subj_x1         (subj_x1),
		.subj_y1         (subj_y1),
		.ref_x0          (ref_x0),
		.ref_y0          (ref_y0),
		.ref_x1          (ref_x1),
		.ref_y1          (ref_y1),
		.line_number     (line_number),
		.segment_number  (segment_number),
		.last_of_query   (last_of_query),
		.cmd             (cmd),
		.st              (st),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.match_found     (match_found),
		.best_score      (best_score),
		.mean_x0         (mean_x0),
		.mean_y0         (mean_y0),
		.mean_x1         (mean_x1),
		.mean_y1         (mean_y1),
		.matched_line    (matched_line),
		.matched_segment (matched_segment),
		.was_reversed    (was_reversed)
	);

endmodule
`default_nettype wire

// ===== verif/segment_match_scorer_unit_tb.sv =====
`timescale 1ns / 1ps
module segment_match_scorer_unit_tb;
	import smsu_pkg::*;

	localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam longint PIH = 64'sd1686629713;
	localparam longint unsigned INVK = 64'd652032874;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [COORD_W-1:0] c[8];
		logic [LINE_W-1:0] line;
		logic [SEG_W-1:0] seg;
		logic last;
		bit zero_exp;
	} request_t;

	typedef struct {
		logic match;
		logic [SCORE_W-1:0] score;
		logic signed [COORD_W-1:0] mean[4];
		logic [LINE_W-1:0] line;
		logic [SEG_W-1:0] seg;
		logic rev;
	} result_t;

	logic clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready, last_of_query;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic signed [COORD_W-1:0] subj_x0, subj_y0, subj_x1, subj_y1;
	logic signed [COORD_W-1:0] ref_x0, ref_y0, ref_x1, ref_y1;
	logic [LINE_W-1:0] line_number, matched_line;
	logic [SEG_W-1:0] segment_number, matched_segment;
	logic match_found, was_reversed;
	logic [SCORE_W-1:0] best_score;
	logic signed [COORD_W-1:0] mean_x0, mean_y0, mean_x1, mean_y1;

	segment_match_scorer_unit uut (.*);

	longint unsigned tol_q, mtol_q, dmax_q;
	longint unsigned best_q;
	longint best_coord[4];
	logic [LINE_W-1:0] best_line;
	logic [SEG_W-1:0] best_seg;
	logic best_rev;

	result_t pending_results[$];
	int mismatches = 0;
	int burst_left = 0;
	longint unsigned atan_tab[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned cordic_mag(longint unsigned ax, longint unsigned ay,
			output longint ang);
		longint unsigned mx, xm, m;
		longint x, y, z, a, nx;
		int sh;
		ang = 0;
		if (ax == 0 && ay == 0) return 0;
		sh = 0;
		mx = ax > ay ? ax : ay;
		while (mx >= (64'd1 << 53)) begin
			ax >>= 1; ay >>= 1; mx >>= 1; sh++;
		end
		while (mx < (64'd1 << 52)) begin
			ax <<= 1; ay <<= 1; mx <<= 1; sh--;
		end
		x = ax; y = ay; z = 0;
		for (int i = 0; i < 31; i++) begin
			a = i < 11 ? longint'(atan_tab[i]) : (64'sd1 << (30 - i));
			if (y >= 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z += a;
			end else begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= a;
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > PIH) z = PIH;
		ang = z;
		xm = x < 0 ? 0 : x;
		m = (xm >> 30) * INVK + (((xm & 64'h3FFF_FFFF) * INVK) >> 30);
		if (sh > 0) m <<= sh; else m >>= -sh;
		return m;
	endfunction

	function automatic longint unsigned seg_len(longint dx, longint dy);
		longint dummy;
		return cordic_mag(mag(dx), mag(dy), dummy);
	endfunction

	function automatic bit score_candidate(request_t q, output result_t r);
		longint s[4], c[4], rr[4];
		longint ux, uy, vx, vy, px, py, qx, qy, dot, crs, z;
		longint unsigned two_tol, l1, l2, diff, dsum, s1, s2, s3, score;
		bit rev, found;
		two_tol = 2 * tol_q;
		score = 0;
		for (int k = 0; k < 4; k++) begin
			s[k] = q.c[k]; c[k] = q.c[4 + k];
		end
		ux = s[2] - s[0]; uy = s[3] - s[1];
		vx = c[2] - c[0]; vy = c[3] - c[1];
		px = ux; py = uy; qx = vx; qy = vy;
		while (mag(px) >= (64'd1 << 30) || mag(py) >= (64'd1 << 30)) begin
			px = px >>> 1; py = py >>> 1;
		end
		while (mag(qx) >= (64'd1 << 30) || mag(qy) >= (64'd1 << 30)) begin
			qx = qx >>> 1; qy = qy >>> 1;
		end
		dot = px * qx + py * qy;
		crs = px * qy - py * qx;
		rev = dot < 0;
		if (rev) rr = '{c[2], c[3], c[0], c[1]};
		else rr = c;
		if (seg_len((s[0] + s[2]) - (c[0] + c[2]), (s[1] + s[3]) - (c[1] + c[3])) < two_tol
				&& !(ux == 0 && uy == 0) && !(vx == 0 && vy == 0)) begin
			void'(cordic_mag(mag(dot), mag(crs), z));
			if (crs == 0) z = 0;
			else if (dot == 0) z = PIH;
			l1 = seg_len(ux, uy);
			l2 = seg_len(vx, vy);
			diff = l1 > l2 ? l1 - l2 : l2 - l1;
			dsum = seg_len(s[0] - rr[0], s[1] - rr[1]) + seg_len(s[2] - rr[2], s[3] - rr[3]);
			if (dmax_q != 0 && diff < dmax_q && dsum < two_tol) begin
				s1 = ((dmax_q - diff) << 16) / dmax_q;
				s2 = (longint'(PIH - z) << 16) / PIH;
				s3 = ((two_tol - dsum) << 16) / two_tol;
				if (s1 > 65536) s1 = 65536;
				if (s1 > mtol_q && s2 > mtol_q && s3 > mtol_q) score = (s1 + s2 + s3) / 3;
			end
		end
		if (score > best_q) begin
			best_q = score;
			best_coord = rr;
			best_line = q.line;
			best_seg = q.seg;
			best_rev = rev;
		end
		if (!q.last) return 0;
		found = best_q > mtol_q;
		r.match = found;
		r.score = best_q[SCORE_W-1:0];
		for (int k = 0; k < 4; k++)
			r.mean[k] = found ? COORD_W'((s[k] + best_coord[k]) >>> 1) : '0;
		r.line = found ? best_line : '0;
		r.seg = found ? best_seg : '0;
		r.rev = found ? best_rev : 1'b0;
		best_q = 0;
		best_coord = '{0, 0, 0, 0};
		best_line = '0;
		best_seg = '0;
		best_rev = 0;
		return 1;
	endfunction

	task automatic write_reg(logic [CIDX_W-1:0] idx, longint unsigned val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val[CFG_W-1:0];
		@(posedge clk);
		case (idx)
			CFG_TOL: tol_q = val & 64'h7FFF_FFFF;
			CFG_MTOL: mtol_q = val & 64'h1FFFF;
			CFG_DMAX: dmax_q = val & 64'hFFFF_FFFF;
			default: ;
		endcase
	endtask

	task automatic configure(longint unsigned tol, longint unsigned mt, longint unsigned dm);
		@(negedge clk);
		in_valid = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_TOL, tol);
		write_reg(CFG_MTOL, mt);
		write_reg(CFG_DMAX, dm);
		write_reg(CFG_UNUSED, $urandom);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic send(request_t q);
		result_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				in_valid = 0;
				repeat ($urandom_range(0, 30)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1;
		{subj_x0, subj_y0, subj_x1, subj_y1} = {q.c[0], q.c[1], q.c[2], q.c[3]};
		{ref_x0, ref_y0, ref_x1, ref_y1} = {q.c[4], q.c[5], q.c[6], q.c[7]};
		line_number = q.line;
		segment_number = q.seg;
		last_of_query = q.last;
		do @(posedge clk); while (!in_ready);
		if (score_candidate(q, r)) begin
			if (q.zero_exp) r = '{1'b0, '0, '{0, 0, 0, 0}, '0, '0, 1'b0};
			pending_results.insert(pending_results.size(), r);
		end
	endtask

	function automatic request_t mk(longint sx0, longint sy0, longint sx1, longint sy1,
			longint rx0, longint ry0, longint rx1, longint ry1, int ln, int sg, bit last,
			bit zero_exp);
		request_t q;
		q.c = '{COORD_W'(sx0), COORD_W'(sy0), COORD_W'(sx1), COORD_W'(sy1),
			COORD_W'(rx0), COORD_W'(ry0), COORD_W'(rx1), COORD_W'(ry1)};
		q.line = LINE_W'(ln);
		q.seg = SEG_W'(sg);
		q.last = last;
		q.zero_exp = zero_exp;
		return q;
	endfunction

	function automatic longint jitter(longint n);
		return longint'($urandom_range(0, 2 * n)) - n;
	endfunction

	int mode_left = 0, mode = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			mode = $urandom_range(0, 2);
			mode_left = $urandom_range(50, 400);
		end
		mode_left--;
		case (mode)
			0: out_ready = 1;
			1: out_ready = $urandom_range(0, 1);
			default: out_ready = ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
			end else begin
				e = pending_results.pop_front();
				if (match_found !== e.match || best_score !== e.score || mean_x0 !== e.mean[0]
						|| mean_y0 !== e.mean[1] || mean_x1 !== e.mean[2]
						|| mean_y1 !== e.mean[3] || matched_line !== e.line
						|| matched_segment !== e.seg || was_reversed !== e.rev) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch at %0t: exp %b %0d %0d %0d %0d %0d %0d %0d %b",
							$realtime, e.match, e.score, e.mean[0], e.mean[1], e.mean[2],
							e.mean[3], e.line, e.seg, e.rev);
						$display("  got %b %0d %0d %0d %0d %0d %0d %0d %b",
							match_found, best_score, mean_x0, mean_y0, mean_x1, mean_y1,
							matched_line, matched_segment, was_reversed);
					end
				end
			end
		end
	end

	initial begin
		request_t dir_tab[$];
		request_t q;
		longint sc, base_x, base_y, n, c[8];
		longint unsigned tol, mt, dm;
		int qlen, count;
		arst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0; in_valid = 0;
		subj_x0 = 0; subj_y0 = 0; subj_x1 = 0; subj_y1 = 0;
		ref_x0 = 0; ref_y0 = 0; ref_x1 = 0; ref_y1 = 0;
		line_number = 0; segment_number = 0; last_of_query = 0;
		tol_q = 0; mtol_q = 45875; dmax_q = 0;
		best_q = 0; best_coord = '{0, 0, 0, 0}; best_line = 0; best_seg = 0; best_rev = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// With the reset settings a zero tolerance rejects everything.
		dir_tab.insert(dir_tab.size(), mk(0, 0, 25600, 0, 0, 0, 25600, 0, 1, 1, 1, 1));
		dir_tab.insert(dir_tab.size(), mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh80000000,
			-32'sh80000000, -32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh80000000,
			255, 4095, 0, 0));
		dir_tab.insert(dir_tab.size(), mk(-32'sh80000000, -32'sh80000000, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, -1, -1, -1, -1, 0, 0, 1, 1));
		foreach (dir_tab[i]) send(dir_tab[i]);
		dir_tab.delete();

		configure(25600, 45875, 256000);
		dir_tab.insert(dir_tab.size(), mk(0, 0, 25600, 0, 0, 0, 25600, 0, 7, 3, 1, 0));
		dir_tab.insert(dir_tab.size(), mk(0, 0, 25600, 0, 25600, 0, 0, 0, 8, 4, 1, 0));
		dir_tab.insert(dir_tab.size(), mk(100, 100, 100, 100, 100, 100, 300, 300, 9, 5, 1, 0));
		dir_tab.insert(dir_tab.size(), mk(0, 0, 25600, 0, 12800, 0, 12800, 0, 9, 5, 1, 0));
		dir_tab.insert(dir_tab.size(),
			mk(0, 0, 25600, 0, 12800, -12800, 12800, 12800, 9, 6, 1, 0));
		dir_tab.insert(dir_tab.size(),
			mk(0, 0, 25600, 0, 0, 20000, 25600, -20000, 9, 7, 1, 0));
		dir_tab.insert(dir_tab.size(), mk(0, 0, 25600, 0, 10, 10, 25610, 10, 1, 11, 0, 0));
		dir_tab.insert(dir_tab.size(), mk(0, 0, 25600, 0, 10, 10, 25610, 10, 2, 12, 1, 0));
		dir_tab.insert(dir_tab.size(), mk(0, 0, 25600, 0, 50, 0, 25650, 0, 3, 0, 0, 0));
		dir_tab.insert(dir_tab.size(), mk(0, 40, 25600, 40, 0, 0, 25600, 0, 4, 4095, 1, 0));
		dir_tab.insert(dir_tab.size(),
			mk(-1000, 5, 24600, 5, -900, 0, 24700, 300, 255, 13, 0, 0));
		dir_tab.insert(dir_tab.size(),
			mk(-1000, 5, 24600, 5, 24600, 0, -1000, 0, 254, 14, 1, 0));
		foreach (dir_tab[i]) send(dir_tab[i]);

		for (int ph = 0; ph < 6; ph++) begin
			sc = 64'sd1 << $urandom_range(6, 24);
			case (ph)
				0: begin tol = 31'h7FFF_FFFF; mt = 0; dm = 32'hFFFF_FFFF; end
				1: begin tol = sc * 2; mt = 65536; dm = sc; end
				2: begin tol = sc * 2; mt = 30000; dm = 0; end
				default: begin
					tol = sc * $urandom_range(1, 3);
					mt = $urandom_range(20000, 60000);
					dm = sc * $urandom_range(1, 4);
				end
			endcase
			configure(tol, mt, dm);
			count = 0;
			while (count < 215) begin
				qlen = $urandom_range(1, 6);
				base_x = jitter(64'sd1 << 28);
				base_y = jitter(64'sd1 << 28);
				c[0] = base_x + jitter(sc); c[1] = base_y + jitter(sc);
				c[2] = base_x + jitter(sc); c[3] = base_y + jitter(sc);
				n = sc / 8 + 1;
				for (int j = 0; j < qlen; j++) begin
					if ($urandom_range(0, 9) == 0) begin
						for (int k = 0; k < 8; k++) c[k] = $signed($urandom);
					end else begin
						if ($urandom_range(0, 7) == 0) begin
							c[2] = base_x + jitter(sc); c[3] = base_y + jitter(sc);
						end
						if ($urandom_range(0, 1)) begin
							c[4] = c[0] + jitter(n); c[5] = c[1] + jitter(n);
							c[6] = c[2] + jitter(n); c[7] = c[3] + jitter(n);
						end else begin
							c[4] = c[2] + jitter(n); c[5] = c[3] + jitter(n);
							c[6] = c[0] + jitter(n); c[7] = c[1] + jitter(n);
						end
					end
					q = mk(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
						$urandom_range(0, 255), $urandom_range(0, 4095), j == qlen - 1, 0);
					send(q);
					count++;
				end
			end
		end

		@(negedge clk);
		in_valid = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== segment_match_scorer_unit.f =====
rtl/core/smsu_pkg.sv
rtl/core/smsu_cordic.sv
rtl/core/smsu_div.sv
rtl/core/smsu_ctrl.sv
rtl/core/smsu_datapath.sv
rtl/core/segment_match_scorer_unit.sv
verif/segment_match_scorer_unit_tb.sv
